/* rtl/core/grc_pkg.sv */
// grc_pkg: shared constants, types and the sine function of the column renderer
// no dependencies
package grc_pkg;

	localparam int unsigned COLUMNS_DEF   = 120;
	localparam int unsigned ROWS_DEF      = 40;
	localparam int unsigned MAP_SIZE_DEF  = 16;
	localparam int unsigned MAX_DEPTH_DEF = 16;

	localparam int unsigned STEP_Q8   = 26;
	localparam int unsigned FOV_UNITS = 512;

	localparam logic [2:0] REG_MAP_A  = 3'd0;
	localparam logic [2:0] REG_MAP_B  = 3'd1;
	localparam logic [2:0] REG_MAP_C  = 3'd2;
	localparam logic [2:0] REG_MAP_D  = 3'd3;
	localparam logic [2:0] REG_POS_X  = 3'd4;
	localparam logic [2:0] REG_POS_Y  = 3'd5;
	localparam logic [2:0] REG_ANGLE  = 3'd6;

	localparam logic [2:0] GLYPH_BLANK = 3'd0;
	localparam logic [2:0] GLYPH_FULL  = 3'd1;
	localparam logic [2:0] GLYPH_DARK  = 3'd2;
	localparam logic [2:0] GLYPH_MED   = 3'd3;
	localparam logic [2:0] GLYPH_LIGHT = 3'd4;
	localparam logic [2:0] GLYPH_FLOOR = 3'd5;

	// job handed from the ray front to the row back
	typedef struct packed {
		logic [12:0] depth;
		logic [2:0]  shade;
	} grc_job_t;

	function automatic logic [11:0] qsine(input logic [4:0] i);
		logic [11:0] v;
		case (i)
			5'd0: v = 12'd0;     5'd1: v = 12'd401;   5'd2: v = 12'd799;
			5'd3: v = 12'd1189;  5'd4: v = 12'd1567;  5'd5: v = 12'd1931;
			5'd6: v = 12'd2276;  5'd7: v = 12'd2598;  5'd8: v = 12'd2896;
			5'd9: v = 12'd3166;  5'd10: v = 12'd3406; 5'd11: v = 12'd3612;
			5'd12: v = 12'd3784; 5'd13: v = 12'd3920; 5'd14: v = 12'd4017;
			5'd15: v = 12'd4076;
			default: v = 12'd0;
		endcase
		return v;
	endfunction

	// q1.12 sine, interpolated quarter wave; 14-bit signed result
	function automatic logic signed [13:0] sine_q12(input logic [11:0] a);
		logic [1:0]  quad;
		logic [10:0] r;
		logic [4:0]  idx;
		logic [5:0]  frac;
		logic [12:0] lo, hi, v;
		logic [18:0] t;
		quad = a[11:10];
		r    = {1'b0, a[9:0]};
		if (quad[0])
			r = 11'd1024 - r;
		idx  = r[10:6];
		frac = r[5:0];
		if (idx >= 5'd16) begin
			v = 13'd4096;
		end else begin
			lo = {1'b0, qsine(idx)};
			hi = (idx == 5'd15) ? 13'd4096 : {1'b0, qsine(idx + 5'd1)};
			t  = 19'((hi - lo) * frac) + 19'd32;
			v  = lo + 13'(t >> 6);
		end
		return quad[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
	endfunction

endpackage

/* rtl/core/grc_ray_front.sv */
// grc_ray_front: accepts a column, marches its ray, divides for the ceiling row
// depends on grc_pkg
module grc_ray_front #(
	parameter int unsigned COLUMNS   = grc_pkg::COLUMNS_DEF,
	parameter int unsigned ROWS      = grc_pkg::ROWS_DEF,
	parameter int unsigned MAP_SIZE  = grc_pkg::MAP_SIZE_DEF,
	parameter int unsigned MAX_DEPTH = grc_pkg::MAX_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [6:0]        col,
	input  logic [255:0]      map_bits,
	input  logic [11:0]       pos_x,
	input  logic [11:0]       pos_y,
	input  logic [11:0]       angle,
	output logic              job_valid,
	input  logic              job_ready,
	output grc_pkg::grc_job_t job,
	output logic signed [7:0] ceil_row
);
	import grc_pkg::*;

	localparam int LIMIT = MAX_DEPTH * 256;
	// reciprocal of the column count, exact for every 16-bit numerator
	localparam longint unsigned COL_RECIP =
		((64'd1 << 32) + 64'(COLUMNS) - 64'd1) / 64'(COLUMNS);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MARCH = 4'b0010,
		S_DIV = 4'b0100,
		S_DONE = 4'b1000
	} st_t;

	st_t st_q;
	logic signed [13:0] ex_q, ey_q;
	logic [13:0] d_q;
	logic [13:0] num_q;    // |ROWS*(d-512)| shifted remainder
	logic [13:0] den_q;
	logic [5:0]  quo_q;
	logic        ovf_q;    // quotient bits beyond six were set
	logic        neg_q;
	logic [4:0]  dcnt_q;
	logic [2:0]  shade_q;
	logic [20:0] nsh_q;

	logic [15:0] col_x;
	logic [48:0] col_prod;
	logic [11:0] ang_w;
	logic [13:0] d_next;
	logic signed [34:0] px, py;
	logic signed [35:0] cx, cy;
	logic out_w, wall_w;
	logic [3:0] ry, rx;
	logic [13:0] dfin;
	logic signed [21:0] nwide;
	logic [20:0] nabs;
	logic [14:0] sh_w;

	assign col_x    = 16'(col * FOV_UNITS);
	assign col_prod = col_x * 33'(COL_RECIP);
	assign ang_w    = angle - 12'(FOV_UNITS / 2) + col_prod[43:32];
	assign d_next   = d_q + 14'(STEP_Q8);

	assign px = $signed({23'd0, pos_x}) * 35'sd4096 + ex_q * $signed({21'd0, d_next});
	assign py = $signed({23'd0, pos_y}) * 35'sd4096 + ey_q * $signed({21'd0, d_next});
	assign cx = px < 0 ? -$signed({1'b0, 35'(-px) >> 20}) : $signed({1'b0, px >>> 20});
	assign cy = py < 0 ? -$signed({1'b0, 35'(-py) >> 20}) : $signed({1'b0, py >>> 20});
	assign out_w = cx < 0 || cx >= MAP_SIZE || cy < 0 || cy >= MAP_SIZE;
	assign ry = cy[3:0];
	assign rx = cx[3:0];
	assign wall_w = map_bits[{ry, rx}];
	assign dfin = (d_q > 14'(LIMIT)) ? 14'(LIMIT) : d_q;
	assign nwide = 22'(ROWS) * ($signed({8'd0, dfin}) - 22'sd512);
	assign nabs  = nwide < 0 ? 21'(-nwide) : 21'(nwide);
	assign sh_w  = {num_q, nsh_q[20]};

	assign in_ready  = st_q == S_IDLE;
	assign job_valid = st_q == S_DONE;
	assign job.depth = dfin[12:0];
	assign job.shade = shade_q;
	// a negative ceiling below -1 blanks nothing, same as -1
	assign ceil_row  = !neg_q ? $signed({2'b0, quo_q})
		: ((quo_q != 6'd0 || ovf_q) ? -8'sd1 : 8'sd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						ex_q <= sine_q12(ang_w);
						ey_q <= sine_q12(ang_w + 12'd1024);
						d_q  <= '0;
						st_q <= S_MARCH;
					end
				end
				S_MARCH: begin
					if (d_q >= 14'(LIMIT)) begin
						st_q <= S_DIV;
					end else begin
						d_q <= out_w ? 14'(LIMIT) : d_next;
						if (out_w || wall_w)
							st_q <= S_DIV;
					end
					dcnt_q <= '0;
				end
				S_DIV: begin
					// loads the operands, then 21 restoring steps
					if (dcnt_q == 5'd0) begin
						nsh_q <= nabs;
						neg_q <= nwide < 0;
						den_q <= {dfin[12:0], 1'b0};
						num_q <= '0;
						quo_q <= '0;
						ovf_q <= 1'b0;
						if (dfin * 4 < 14'(LIMIT))      shade_q <= GLYPH_FULL;
						else if (dfin * 3 < 14'(LIMIT)) shade_q <= GLYPH_DARK;
						else if (dfin * 2 < 14'(LIMIT)) shade_q <= GLYPH_MED;
						else if (dfin < 14'(LIMIT))     shade_q <= GLYPH_LIGHT;
						else                            shade_q <= GLYPH_BLANK;
					end else begin
						nsh_q <= nsh_q << 1;
						if (sh_w >= {1'b0, den_q}) begin
							num_q <= 14'(sh_w - {1'b0, den_q});
							quo_q <= {quo_q[4:0], 1'b1};
						end else begin
							num_q <= sh_w[13:0];
							quo_q <= {quo_q[4:0], 1'b0};
						end
						ovf_q <= ovf_q | quo_q[5];
						if (dcnt_q == 5'd21)
							st_q <= S_DONE;
					end
					dcnt_q <= dcnt_q + 5'd1;
				end
				S_DONE: begin
					if (job_ready)
						st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/grc_row_back.sv */
// grc_row_back: one-entry job queue and row emitter
// depends on grc_pkg
module grc_row_back #(
	parameter int unsigned ROWS = grc_pkg::ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_ready,
	input  grc_pkg::grc_job_t job,
	input  logic signed [7:0] ceil_row,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [5:0]        row,
	output logic [2:0]        glyph,
	output logic [12:0]       wall_distance,
	output logic              last_row
);
	import grc_pkg::*;

	grc_job_t job_q;
	logic signed [7:0] ceil_q, floor_q;
	logic busy_q;
	logic [5:0] y_q;
	logic signed [7:0] ys;

	assign job_ready = !busy_q;
	assign out_valid = busy_q;
	assign ys = $signed({2'b0, y_q});
	assign row = y_q;
	assign wall_distance = job_q.depth;
	assign last_row = y_q == 6'(ROWS - 1);
	always_comb begin
		if (ys <= ceil_q)       glyph = GLYPH_BLANK;
		else if (ys <= floor_q) glyph = job_q.shade;
		else                    glyph = GLYPH_FLOOR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			y_q <= '0;
		end else if (!busy_q) begin
			if (job_valid) begin
				busy_q  <= 1'b1;
				y_q     <= '0;
				job_q   <= job;
				ceil_q  <= ceil_row;
				floor_q <= 8'(ROWS) - ceil_row;
			end
		end else if (out_ready) begin
			if (last_row)
				busy_q <= 1'b0;
			y_q <= y_q + 6'd1;
		end
	end

endmodule

/* rtl/core/grid_raycast_column_renderer_core.sv */
// grid_raycast_column_renderer_core: top level, config registers and the two halves
// depends on grc_pkg, grc_ray_front, grc_row_back
//
// one column word in, ROWS row words out. the front marches the ray one
// 26/256 step per cycle, then a restoring divide gives the ceiling row;
// the back emits one row a cycle unless out_ready holds it, while the
// front already takes the next column. the user must make apb writes
// only while idle; the block itself does not enforce this.
module grid_raycast_column_renderer_core #(
	parameter int unsigned COLUMNS   = grc_pkg::COLUMNS_DEF,
	parameter int unsigned ROWS      = grc_pkg::ROWS_DEF,
	parameter int unsigned MAP_SIZE  = grc_pkg::MAP_SIZE_DEF,
	parameter int unsigned MAX_DEPTH = grc_pkg::MAX_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [6:0]  column,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  row,
	output logic [2:0]  glyph,
	output logic [12:0] wall_distance,
	output logic        last_row
);
	import grc_pkg::*;

	logic [255:0] map_q;
	logic [11:0] px_q, py_q, ang_q;
	logic [2:0] idx;
	logic wr;

	assign pready = 1'b1;
	assign idx = paddr[5:3];
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= '0;
			px_q <= 12'd2048;
			py_q <= 12'd2048;
			ang_q <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_MAP_A: map_q[63:0]    <= pwdata;
				REG_MAP_B: map_q[127:64]  <= pwdata;
				REG_MAP_C: map_q[191:128] <= pwdata;
				REG_MAP_D: map_q[255:192] <= pwdata;
				REG_POS_X: px_q  <= pwdata[11:0];
				REG_POS_Y: py_q  <= pwdata[11:0];
				REG_ANGLE: ang_q <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MAP_A: prdata = map_q[63:0];
			REG_MAP_B: prdata = map_q[127:64];
			REG_MAP_C: prdata = map_q[191:128];
			REG_MAP_D: prdata = map_q[255:192];
			REG_POS_X: prdata = {52'd0, px_q};
			REG_POS_Y: prdata = {52'd0, py_q};
			REG_ANGLE: prdata = {52'd0, ang_q};
			default:   prdata = '0;
		endcase
	end

	// front to back handoff
	grc_job_t job;
	logic job_valid, job_ready;
	logic signed [7:0] ceil_row;

	grc_ray_front #(.COLUMNS(COLUMNS), .ROWS(ROWS), .MAP_SIZE(MAP_SIZE),
		.MAX_DEPTH(MAX_DEPTH)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.col(column), .map_bits(map_q), .pos_x(px_q), .pos_y(py_q), .angle(ang_q),
		.job_valid(job_valid), .job_ready(job_ready), .job(job), .ceil_row(ceil_row)
	);

	grc_row_back #(.ROWS(ROWS)) u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job_ready(job_ready),
		.job(job), .ceil_row(ceil_row), .out_valid(out_valid), .out_ready(out_ready),
		.row(row), .glyph(glyph), .wall_distance(wall_distance), .last_row(last_row)
	);

endmodule

/* rtl/core/grc_checker.sv */
// grc_checker: port-level checks of the column renderer
// depends on grid_raycast_column_renderer_core
module grc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [5:0] row,
	input logic [2:0] glyph,
	input logic [12:0] wall_distance,
	input logic       last_row,
	input logic       pready
);
	a_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> glyph <= 3'd5) else $error("glyph code out of range");
	a_next_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_row |=> out_valid && row == $past(row) + 6'd1)
		else $error("row sequence broken");
	a_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_row |=> $stable(wall_distance))
		else $error("distance changed within a column");
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind grid_raycast_column_renderer_core grc_checker u_grc_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.row(row), .glyph(glyph), .wall_distance(wall_distance), .last_row(last_row),
	.pready(pready)
);
